@@ hdl/scp_pkg.sv @@
package scp_pkg;

	// Record and window geometry
	localparam int SAMPLE_BITS = 10;
	localparam int MAX_WINDOW  = 31;
	localparam int PEAK_WINDOW = 5;
	localparam int PEAK_HALF   = PEAK_WINDOW / 2;
	localparam int PEAK_SPAN   = 2 * PEAK_HALF + 1;
	localparam int HALF_MAX    = (MAX_WINDOW - 1) / 2;

	// Register and field widths
	localparam int WIN_BITS      = 5;
	localparam int THR_BITS      = SAMPLE_BITS;
	localparam int COUNT_BITS    = 16;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = (WIN_BITS > THR_BITS) ? WIN_BITS : THR_BITS;

	// Smoothed values can exceed the raw range (even windows average 2h+1 terms
	// over 2h), so the window and peak history carry extra headroom.
	localparam int VAL_BITS     = SAMPLE_BITS + 6;
	localparam int IDX_BITS     = $clog2(MAX_WINDOW);
	localparam int SUM_BITS     = VAL_BITS + $clog2(MAX_WINDOW + 1);
	localparam int DIV_CNT_BITS = $clog2(SUM_BITS);
	localparam int FILL_BITS    = $clog2(PEAK_SPAN + 1);

	localparam logic [WIN_BITS-1:0] SMOOTH_WINDOW_RST  = WIN_BITS'(5);
	localparam logic [THR_BITS-1:0] PEAK_THRESHOLD_RST = THR_BITS'(520);

	typedef logic [VAL_BITS-1:0]   val_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SMOOTH_WINDOW  = 1'b0,
		CFG_PEAK_THRESHOLD = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_WRITE,
		ST_EMIT,
		ST_FLUSH,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic                shift;
		logic                wr;
		logic                clr;
		logic [IDX_BITS-1:0] idx;
	} win_ctrl_t;

	typedef struct packed {
		logic clr;
		logic acc;
		logic div;
	} arith_ctrl_t;

	typedef struct packed {
		logic emit;
		logic clr;
	} peak_ctrl_t;

endpackage

@@ hdl/scp_ifs.sv @@
interface scp_in_if import scp_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   end_of_record;

	modport source (output valid, output sample, output end_of_record, input ready);
	modport sink (input valid, input sample, input end_of_record, output ready);
endinterface

interface scp_out_if import scp_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] smoothed_value;
	logic [COUNT_BITS-1:0]  peak_total;
	logic                   final_result;

	modport source (output valid, output smoothed_value, output peak_total,
		output final_result, input ready);
	modport sink (input valid, input smoothed_value, input peak_total,
		input final_result, output ready);
endinterface

interface scp_cfg_if import scp_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/scp_window.sv @@
module scp_window import scp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  win_ctrl_t              ctrl,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  val_t                   wr_data,
	output val_t                   rd_data
);

	// Newest value at index 0
	val_t win_q [MAX_WINDOW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WINDOW; i++) win_q[i] <= '0;
		end else if (ctrl.clr) begin
			for (int i = 0; i < MAX_WINDOW; i++) win_q[i] <= '0;
		end else if (ctrl.shift) begin
			win_q[0] <= VAL_BITS'(sample);
			for (int i = 1; i < MAX_WINDOW; i++) win_q[i] <= win_q[i-1];
		end else if (ctrl.wr) begin
			win_q[ctrl.idx] <= wr_data;
		end
	end

	assign rd_data = win_q[ctrl.idx];

endmodule

@@ hdl/scp_arith.sv @@
module scp_arith import scp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  arith_ctrl_t         ctrl,
	input  val_t                tap,
	input  logic [WIN_BITS-1:0] divisor,
	output val_t                quotient
);

	logic [SUM_BITS-1:0] acc_q;
	logic [WIN_BITS-1:0] rem_q;
	logic [WIN_BITS:0]   partial;
	logic [SUM_BITS-1:0] op_a;
	logic [SUM_BITS-1:0] op_b;
	logic                sub;
	logic [SUM_BITS:0]   res;
	logic                qbit;

	// Restoring division: the sum shifts out of the top of acc_q while the
	// quotient bits shift into its bottom.
	assign partial = {rem_q, acc_q[SUM_BITS-1]};

	// One shared add/subtract unit for both accumulation and division
	always_comb begin
		if (ctrl.div) begin
			op_a = SUM_BITS'(partial);
			op_b = SUM_BITS'(divisor);
			sub  = 1'b1;
		end else begin
			op_a = acc_q;
			op_b = SUM_BITS'(tap);
			sub  = 1'b0;
		end
		res  = sub ? ({1'b0, op_a} - {1'b0, op_b}) : ({1'b0, op_a} + {1'b0, op_b});
		qbit = ~res[SUM_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			rem_q <= '0;
		end else if (ctrl.clr) begin
			acc_q <= '0;
			rem_q <= '0;
		end else if (ctrl.acc) begin
			acc_q <= res[SUM_BITS-1:0];
		end else if (ctrl.div) begin
			acc_q <= {acc_q[SUM_BITS-2:0], qbit};
			rem_q <= qbit ? res[WIN_BITS-1:0] : partial[WIN_BITS-1:0];
		end
	end

	assign quotient = acc_q[VAL_BITS-1:0];

endmodule

@@ hdl/scp_peak.sv @@
module scp_peak import scp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  peak_ctrl_t          ctrl,
	input  val_t                value,
	input  logic [THR_BITS-1:0] threshold,
	output count_t              count_next
);

	val_t                 hist_q [PEAK_SPAN];
	logic [FILL_BITS-1:0] fill_q;
	count_t               cnt_q;
	logic                 hit;

	// Judge the window as it stands once value has entered it
	always_comb begin
		val_t nh [PEAK_SPAN];
		val_t c;
		nh[0] = value;
		for (int i = 1; i < PEAK_SPAN; i++) nh[i] = hist_q[i-1];
		c   = nh[PEAK_HALF];
		hit = (fill_q >= FILL_BITS'(PEAK_SPAN - 1)) && (c >= VAL_BITS'(threshold));
		for (int i = 0; i < PEAK_HALF; i++)
			if (nh[i] > c) hit = 1'b0;
		for (int i = PEAK_HALF + 1; i < PEAK_SPAN; i++)
			if (nh[i] >= c) hit = 1'b0;
		count_next = (ctrl.emit && hit && (cnt_q != '1)) ? cnt_q + 1'b1 : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PEAK_SPAN; i++) hist_q[i] <= '0;
			fill_q <= '0;
			cnt_q  <= '0;
		end else if (ctrl.clr) begin
			for (int i = 0; i < PEAK_SPAN; i++) hist_q[i] <= '0;
			fill_q <= '0;
			cnt_q  <= '0;
		end else if (ctrl.emit) begin
			hist_q[0] <= value;
			for (int i = 1; i < PEAK_SPAN; i++) hist_q[i] <= hist_q[i-1];
			if (fill_q < FILL_BITS'(PEAK_SPAN)) fill_q <= fill_q + 1'b1;
			cnt_q <= count_next;
		end
	end

endmodule

@@ hdl/smooth_and_count_peaks.sv @@
// Moving-average smoother with a peak counter.
// Channels: samples takes one raw sample per item with end_of_record on the
// last one of a record; results gives smoothed values h = window/2 items late,
// and on end_of_record flushes the remaining tail, the last result carrying
// final_result and the saturating peak_total; cfg writes smooth_window
// (index 0) and peak_threshold (index 1), always ready; the user must
// write them only while idle, as the block itself does not enforce it.
// Per item, the shared add/subtract unit and its sequencer run the accept
// step, then sum the window taps 0 through 2h one tap a cycle, run a
// restoring division over all SUM_BITS (21) bits of the sum, write back and
// emit; before a full window exists, the accept step goes straight to emit.
// The record end adds a flush step per tail position, whether or not it
// holds a value, then a clear step. A result is loaded into the output
// register by its emit or flush step. Reset: registers return to 5 and 520,
// the window, peak history and counters clear, and samples.ready is high.
// A stalled receiver holds the result in the output register; the sequencer
// waits in its emit or flush step until that register frees up.
module smooth_and_count_peaks import scp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	scp_cfg_if.sink  cfg,
	scp_in_if.sink   samples,
	scp_out_if.source results
);

	state_t state_q, state_d;

	logic [WIN_BITS-1:0]     smooth_window_q;
	logic [THR_BITS-1:0]     peak_threshold_q;
	logic [WIN_BITS-1:0]     w_q;
	logic [IDX_BITS-1:0]     h_q;
	logic                    eor_q;
	logic [IDX_BITS-1:0]     seen_q;
	logic [IDX_BITS-1:0]     k_q, k_d;
	logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_value_q;
	count_t                 out_total_q;
	logic                   out_final_q;

	logic [WIN_BITS-1:0] w_now;
	logic [IDX_BITS-1:0] h_now;
	logic [IDX_BITS:0]   twoh_now;
	logic [IDX_BITS:0]   twoh_q;
	logic                load_ok;
	logic                latch;
	logic                seen_inc;
	logic                seen_clr;
	logic                emit_final;

	win_ctrl_t   win_ctrl;
	arith_ctrl_t arith_ctrl;
	peak_ctrl_t  peak_ctrl;
	val_t        win_rd;
	val_t        quotient;
	count_t      count_next;

	// Effective window and half width from the current registers
	always_comb begin
		logic [WIN_BITS-1:0] half;
		w_now = (smooth_window_q == '0) ? WIN_BITS'(1) : smooth_window_q;
		half  = w_now >> 1;
		if (2 * int'(half) + 1 > MAX_WINDOW) h_now = IDX_BITS'(HALF_MAX);
		else h_now = IDX_BITS'(half);
		twoh_now = {h_now, 1'b0};
	end

	assign twoh_q  = {h_q, 1'b0};
	assign load_ok = ~out_valid_q | results.ready;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_window_q  <= SMOOTH_WINDOW_RST;
			peak_threshold_q <= PEAK_THRESHOLD_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				CFG_SMOOTH_WINDOW:  smooth_window_q  <= cfg.data[WIN_BITS-1:0];
				CFG_PEAK_THRESHOLD: peak_threshold_q <= cfg.data[THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Next state and datapath controls
	always_comb begin
		state_d       = state_q;
		k_d           = k_q;
		cnt_d         = cnt_q;
		win_ctrl      = '{shift: 1'b0, wr: 1'b0, clr: 1'b0, idx: k_q};
		arith_ctrl    = '0;
		peak_ctrl     = '0;
		emit_final    = 1'b0;
		latch         = 1'b0;
		seen_inc      = 1'b0;
		seen_clr      = 1'b0;
		samples.ready = 1'b0;

		case (state_q)
			ST_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					// Shift the sample in and clear the accumulator
					win_ctrl.shift = 1'b1;
					arith_ctrl.clr = 1'b1;
					latch          = 1'b1;
					k_d            = '0;
					if ({1'b0, seen_q} >= twoh_now) state_d = ST_SUM;
					else state_d = ST_EMIT;
				end
			end
			ST_SUM: begin
				// Add one tap per cycle, taps 0 through 2h
				arith_ctrl.acc = 1'b1;
				if ({1'b0, k_q} == twoh_q) begin
					cnt_d   = '0;
					state_d = ST_DIV;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			ST_DIV: begin
				arith_ctrl.div = 1'b1;
				if (cnt_q == DIV_CNT_BITS'(SUM_BITS - 1)) state_d = ST_WRITE;
				else cnt_d = cnt_q + 1'b1;
			end
			ST_WRITE: begin
				// Replace the centre with the average
				win_ctrl.idx = h_q;
				win_ctrl.wr  = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				win_ctrl.idx = h_q;
				if (seen_q < h_q || load_ok) begin
					if (seen_q >= h_q) begin
						peak_ctrl.emit = 1'b1;
						emit_final     = eor_q && (h_q == '0);
					end
					if (eor_q) begin
						if (h_q == '0) begin
							state_d = ST_CLEAR;
						end else begin
							k_d     = h_q - 1'b1;
							state_d = ST_FLUSH;
						end
					end else begin
						seen_inc = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				// Drain the newest h values, oldest first, skipping unfilled taps
				if (k_q > seen_q || load_ok) begin
					if (k_q <= seen_q) begin
						peak_ctrl.emit = 1'b1;
						emit_final     = (k_q == '0);
					end
					if (k_q == '0) state_d = ST_CLEAR;
					else k_d = k_q - 1'b1;
				end
			end
			ST_CLEAR: begin
				win_ctrl.clr  = 1'b1;
				peak_ctrl.clr = 1'b1;
				seen_clr      = 1'b1;
				state_d       = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer counters and per-item context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			cnt_q  <= '0;
			w_q    <= SMOOTH_WINDOW_RST;
			h_q    <= '0;
			eor_q  <= 1'b0;
			seen_q <= '0;
		end else begin
			k_q   <= k_d;
			cnt_q <= cnt_d;
			if (latch) begin
				w_q   <= w_now;
				h_q   <= h_now;
				eor_q <= samples.end_of_record;
			end
			// Saturate: only comparisons against 2h and below matter
			if (seen_clr) seen_q <= '0;
			else if (seen_inc && seen_q != '1) seen_q <= seen_q + 1'b1;
		end
	end

	scp_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (win_ctrl),
		.sample  (samples.sample),
		.wr_data (quotient),
		.rd_data (win_rd)
	);

	scp_arith u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (arith_ctrl),
		.tap      (win_rd),
		.divisor  (w_q),
		.quotient (quotient)
	);

	scp_peak u_peak (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (peak_ctrl),
		.value      (win_rd),
		.threshold  (peak_threshold_q),
		.count_next (count_next)
	);

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (peak_ctrl.emit) out_valid_q <= 1'b1;
		else if (results.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (peak_ctrl.emit) begin
			out_value_q <= win_rd[SAMPLE_BITS-1:0];
			out_total_q <= emit_final ? count_next : '0;
			out_final_q <= emit_final;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.smoothed_value = out_value_q;
	assign results.peak_total     = out_total_q;
	assign results.final_result   = out_final_q;

endmodule

@@ hdl/scp_checker.sv @@
module scp_checker import scp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_value,
	input logic [COUNT_BITS-1:0]  out_total,
	input logic                   out_final
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value) && $stable(out_total)
			&& $stable(out_final))
		else $error("stalled result changed");

	// Peak count only on the last result of a record
	a_total_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_final |-> out_total == '0)
		else $error("peak total on a non-final result");

	// One item at a time: the sequencer leaves idle on accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in progress");

endmodule

bind smooth_and_count_peaks scp_checker u_scp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_value (results.smoothed_value),
	.out_total (results.peak_total),
	.out_final (results.final_result)
);
